[hw/rtl/pms_pkg.sv]
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants of the priority medium stack
// Entry layout, request and result records, operation codes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Default stack depth
  localparam int unsigned MAX_MEDIA_DEF = 8;

  // Fixed field widths of the channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned OBJ_W     = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned MAT_W     = 16;
  localparam int unsigned IOR_W     = 32;
  localparam int unsigned RIDX_W    = 3;
  localparam int unsigned CNT_OUT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } pms_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_REMOVE,
    ST_REPORT
  } pms_state_t;

  // One stack entry
  typedef struct packed {
    logic [OBJ_W-1:0]         obj;
    logic signed [PRIO_W-1:0] prio;
    logic [MAT_W-1:0]         mat;
    logic [IOR_W-1:0]         ior;
  } pms_entry_t;

  // Incoming request
  typedef struct packed {
    pms_op_t                  op;
    logic [OBJ_W-1:0]         obj;
    logic signed [PRIO_W-1:0] prio;
    logic [MAT_W-1:0]         mat;
    logic [IOR_W-1:0]         ior;
    logic [RIDX_W-1:0]        ridx;
  } pms_req_t;

  // Register file write control
  typedef struct packed {
    logic       we;
    pms_entry_t data;
  } pms_wr_t;

  // Result record
  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic                 entry_valid;
    pms_entry_t           entry;
    logic                 lost;
    logic [CNT_OUT_W-1:0] removed;
  } pms_res_t;

endpackage

[hw/rtl/pms_if.sv]
// ----------------------------------------------------------------------------
// pms_if: request and result channels of the priority medium stack
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pms_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [15:0]       object_id;
  logic signed [7:0] priority_req;
  logic [15:0]       material_id;
  logic [31:0]       ior_bits;
  logic [2:0]        read_index;

  modport source (
    output valid, operation, object_id, priority_req, material_id, ior_bits,
           read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, object_id, priority_req, material_id, ior_bits,
           read_index,
    output ready
  );
endinterface

interface pms_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        count;
  logic              entry_valid;
  logic [15:0]       entry_object;
  logic signed [7:0] entry_priority;
  logic [15:0]       entry_material;
  logic [31:0]       entry_ior;
  logic              lost;
  logic [3:0]        removed_count;

  modport source (
    output valid, count, entry_valid, entry_object, entry_priority,
           entry_material, entry_ior, lost, removed_count,
    input  ready
  );
  modport sink (
    input  valid, count, entry_valid, entry_object, entry_priority,
           entry_material, entry_ior, lost, removed_count,
    output ready
  );
endinterface

[hw/rtl/pms_regfile.sv]
// ----------------------------------------------------------------------------
// pms_regfile: stack entry storage
// One write port and one combinational read port; positions beyond the
// depth read as zero.
// ----------------------------------------------------------------------------
module pms_regfile #(
  parameter int unsigned MAX_MEDIA = pms_pkg::MAX_MEDIA_DEF,
  parameter int unsigned IDX_W     = (MAX_MEDIA > 1) ? $clog2(MAX_MEDIA) : 1
) (
  input  logic                clk,
  input  pms_pkg::pms_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [IDX_W-1:0]    rd_addr,
  output pms_pkg::pms_entry_t rd_data
);
  import pms_pkg::*;

  pms_entry_t mem_r [MAX_MEDIA];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr_addr] <= wr.data;
    end
  end

  // Read one entry
  always_comb begin
    rd_data = '0;
    if (32'(rd_addr) < MAX_MEDIA) begin
      rd_data = mem_r[rd_addr];
    end
  end

endmodule

[hw/rtl/pms_seq.sv]
// ----------------------------------------------------------------------------
// pms_seq: operation sequencer of the priority medium stack
// Walks the stack one position a cycle through a single compare unit,
// inserting with a carried entry or compacting behind a write pointer.
// ----------------------------------------------------------------------------
module pms_seq #(
  parameter int unsigned MAX_MEDIA = pms_pkg::MAX_MEDIA_DEF,
  parameter int unsigned IDX_W     = (MAX_MEDIA > 1) ? $clog2(MAX_MEDIA) : 1,
  parameter int unsigned CNT_W     = $clog2(MAX_MEDIA + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  pms_pkg::pms_req_t   req,
  output logic [IDX_W-1:0]    rd_addr,
  input  pms_pkg::pms_entry_t rd_data,
  output logic [IDX_W-1:0]    wr_addr,
  output pms_pkg::pms_wr_t    wr,
  output logic                res_valid,
  input  logic                res_free,
  output pms_pkg::pms_res_t   res,
  output logic [CNT_W-1:0]    count
);
  import pms_pkg::*;

  pms_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  pms_req_t          req_r;
  logic [RIDX_W-1:0] rpos_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  wptr_r;
  logic              ins_r;
  pms_entry_t        carry_r;
  logic              lost_r;
  logic [CNT_W-1:0]  removed_r;

  logic              accept;
  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  add_last;
  logic              add_done;
  logic              rem_done;
  logic              take_new;
  logic              keep;
  logic [CNT_W-1:0]  wptr_inc;
  pms_entry_t        new_entry;

  assign accept = req_valid && req_ready;
  assign count  = count_r;

  // Shared compare unit and loop bounds
  assign idx_ext   = CNT_W'(idx_r);
  assign add_last  = (32'(count_r) < MAX_MEDIA) ? count_r : CNT_W'(MAX_MEDIA - 1);
  assign add_done  = (idx_ext == add_last);
  assign rem_done  = ((32'(idx_ext) + 32'd1) == 32'(count_r));
  assign take_new  = !ins_r && ((idx_ext >= count_r) || (rd_data.prio < req_r.prio));
  assign keep      = (rd_data.obj != req_r.obj);
  assign wptr_inc  = wptr_r + CNT_W'(keep);
  assign new_entry = '{obj: req_r.obj, prio: req_r.prio, mat: req_r.mat, ior: req_r.ior};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            OP_ADD:    state_nxt = ST_ADD;
            OP_REMOVE: state_nxt = (count_r == '0) ? ST_REPORT : ST_REMOVE;
            OP_READ:   state_nxt = ST_REPORT;
            OP_CLEAR:  state_nxt = ST_REPORT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (add_done) state_nxt = ST_REPORT;
      end
      ST_REMOVE: begin
        if (rem_done) state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    rd_addr   = idx_r;
    wr_addr   = idx_r;
    wr        = '0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_ADD: begin
        if (take_new) begin
          wr.we   = 1'b1;
          wr.data = new_entry;
        end else if (ins_r) begin
          wr.we   = 1'b1;
          wr.data = carry_r;
        end
      end
      ST_REMOVE: begin
        wr_addr = IDX_W'(wptr_r);
        wr.we   = keep;
        wr.data = rd_data;
      end
      ST_REPORT: begin
        rd_addr   = IDX_W'(rpos_r);
        res_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Result record
  always_comb begin
    res             = '0;
    res.count       = CNT_OUT_W'(count_r);
    res.entry_valid = (32'(rpos_r) < 32'(count_r));
    res.lost        = lost_r;
    res.removed     = CNT_OUT_W'(removed_r);
    if (res.entry_valid) begin
      res.entry = rd_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (req.op == OP_CLEAR)) begin
        count_r <= '0;
      end else if ((state_r == ST_ADD) && add_done) begin
        if (32'(count_r) < MAX_MEDIA) count_r <= count_r + 1'b1;
      end else if ((state_r == ST_REMOVE) && rem_done) begin
        count_r <= wptr_inc;
      end
    end
  end

  // Operand and loop registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= req;
      rpos_r    <= (req.op == OP_READ) ? req.ridx : '0;
      idx_r     <= '0;
      wptr_r    <= '0;
      ins_r     <= 1'b0;
      lost_r    <= 1'b0;
      removed_r <= '0;
    end else if (state_r == ST_ADD) begin
      if (take_new || ins_r) carry_r <= rd_data;
      ins_r <= ins_r | take_new;
      idx_r <= idx_r + 1'b1;
      if (add_done) lost_r <= (32'(count_r) >= MAX_MEDIA);
    end else if (state_r == ST_REMOVE) begin
      wptr_r <= wptr_inc;
      idx_r  <= idx_r + 1'b1;
      if (rem_done) removed_r <= count_r - wptr_inc;
    end
  end

endmodule

[hw/rtl/priority_medium_stack.sv]
// ----------------------------------------------------------------------------
// priority_medium_stack: bounded stack of media in descending priority
// Add, remove, read and clear operations on up to MAX_MEDIA entries, one
// result transaction for each request transaction.
// ----------------------------------------------------------------------------
// Add walks positions 0 to min(n, MAX_MEDIA-1), remove walks positions 0 to
// n-1 (none on an empty stack), read and clear go straight to the report
// state, n being the count before the operation.
// A new request is taken only once the previous result enters the result
// register; add and remove walk the stack one position a cycle through the register file port.
// Reset: synchronous, active low; empties the stack and the result register.
module priority_medium_stack #(
  parameter int unsigned MAX_MEDIA = pms_pkg::MAX_MEDIA_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pms_in_if.sink    in_ch,
  pms_out_if.source out_ch
);
  import pms_pkg::*;

  localparam int unsigned IDX_W = (MAX_MEDIA > 1) ? $clog2(MAX_MEDIA) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_MEDIA + 1);

  pms_req_t         req;
  logic             req_ready;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  pms_entry_t       rd_data;
  pms_wr_t          wr;
  logic             res_valid;
  logic             res_free;
  pms_res_t         res;
  logic [CNT_W-1:0] stack_count;

  logic             out_valid_r;
  pms_res_t         out_res_r;

  // Pack the request
  assign req.op   = pms_op_t'(in_ch.operation);
  assign req.obj  = in_ch.object_id;
  assign req.prio = in_ch.priority_req;
  assign req.mat  = in_ch.material_id;
  assign req.ior  = in_ch.ior_bits;
  assign req.ridx = in_ch.read_index;
  assign in_ch.ready = req_ready;

  pms_seq #(
    .MAX_MEDIA (MAX_MEDIA),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (req_ready),
    .req       (req),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res       (res),
    .count     (stack_count)
  );

  pms_regfile #(
    .MAX_MEDIA (MAX_MEDIA),
    .IDX_W     (IDX_W)
  ) u_regfile (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register: load when empty or being drained
  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_res_r <= res;
    end
  end

  // Drive the result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.count          = out_res_r.count;
  assign out_ch.entry_valid    = out_res_r.entry_valid;
  assign out_ch.entry_object   = out_res_r.entry.obj;
  assign out_ch.entry_priority = out_res_r.entry.prio;
  assign out_ch.entry_material = out_res_r.entry.mat;
  assign out_ch.entry_ior      = out_res_r.entry.ior;
  assign out_ch.lost           = out_res_r.lost;
  assign out_ch.removed_count  = out_res_r.removed;

  // The stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stack_count) <= MAX_MEDIA)
    else $error("stack count exceeds depth");

  // An accepted request keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while busy");

  // A result never reports both a lost entry and removed entries
  a_lost_removed_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.lost) |-> (res.removed == '0))
    else $error("lost and removed both set");

  // A result handed over while the result register is free is registered as valid
  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_free) |=> out_valid_r)
    else $error("result not registered");

endmodule
